// ----- rtl/core/csrgb_pkg.sv -----
package csrgb_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // x / 255 == (x * magic) >> 39 for any 32-bit x
  localparam logic [31:0] DIV255_MAGIC = 32'h8080_8081;
  localparam int          DIV255_SHIFT = 39;

  // integer bt.601 coefficients
  localparam logic signed [19:0] COEF_Y  = 20'sd298;
  localparam logic signed [19:0] COEF_RV = 20'sd409;
  localparam logic signed [19:0] COEF_GU = 20'sd100;
  localparam logic signed [19:0] COEF_GV = 20'sd208;
  localparam logic signed [19:0] COEF_BU = 20'sd516;
  localparam logic signed [19:0] YUV_RND = 20'sd128;
  localparam logic signed [9:0]  Y_OFS   = 10'sd16;
  localparam logic signed [9:0]  UV_OFS  = 10'sd128;

  typedef enum logic [1:0] {
    MODE_HSV  = 2'd0,
    MODE_HSL  = 2'd1,
    MODE_YUV  = 2'd2,
    MODE_PASS = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] comp_first;
    logic [7:0] comp_second;
    logic [7:0] comp_third;
    logic       end_of_image;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } rgb_t;

  typedef struct packed {
    mode_t mode;
    pix_t  pix;
  } side_t;

  function automatic logic [12:0] div255(input logic [19:0] x);
    logic [51:0] p;
    p = 52'(x) * 52'(DIV255_MAGIC);
    return p[DIV255_SHIFT +: 13];
  endfunction

  // floor(sum/256) clipped to 0..255
  function automatic logic [7:0] clip_yuv(input logic signed [19:0] sum);
    logic [11:0] q;
    q = 12'(sum >>> 8);
    if (sum < 0) begin
      return 8'd0;
    end else if (q > 12'd255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

endpackage

// ----- rtl/core/csrgb_datapath.sv -----
module csrgb_datapath #(
  parameter int FRAC_BITS = csrgb_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_vld,
  input  csrgb_pkg::pix_t    req,
  input  csrgb_pkg::mode_t   mode,
  output logic               rsp_vld,
  output csrgb_pkg::rgb_t    rsp
);

  localparam int FB = FRAC_BITS;
  localparam int KW = FB - 7;
  localparam logic [KW-1:0] K_DIV = KW'((1 << FB) / 255);
  localparam logic [7:0]    R_DIV = 8'((1 << FB) % 255);
  localparam logic [FB:0]   ONE   = {1'b1, {FB{1'b0}}};
  localparam logic [FB+1:0] ONE2  = {2'b01, {FB{1'b0}}};

  // ---------------- stage 1: scale products
  logic [10:0]        hue6;
  logic signed [9:0]  y_s, u_s, v_s;
  logic signed [19:0] py, prv, pgu, pgv, pbu;

  logic                   s1_vld_r;
  csrgb_pkg::side_t       s1_side_r;
  logic [FB+3:0]          s1_vk_r;
  logic [FB:0]            s1_sk_r, s1_tk_r;
  logic [19:0]            s1_vr_r;
  logic [15:0]            s1_sr_r, s1_tr_r;
  logic signed [19:0]     s1_py_r, s1_prv_r, s1_pgu_r, s1_pgv_r, s1_pbu_r;

  assign hue6 = 11'(req.comp_first) * 11'd6;
  assign y_s  = $signed({2'b00, req.comp_first}) - csrgb_pkg::Y_OFS;
  assign u_s  = $signed({2'b00, req.comp_second}) - csrgb_pkg::UV_OFS;
  assign v_s  = $signed({2'b00, req.comp_third}) - csrgb_pkg::UV_OFS;
  assign py   = 20'(y_s) * csrgb_pkg::COEF_Y;
  assign prv  = 20'(v_s) * csrgb_pkg::COEF_RV;
  assign pgu  = 20'(u_s) * csrgb_pkg::COEF_GU;
  assign pgv  = 20'(v_s) * csrgb_pkg::COEF_GV;
  assign pbu  = 20'(u_s) * csrgb_pkg::COEF_BU;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= req_vld;
    end
    s1_side_r <= '{mode: mode, pix: req};
    // v*2^F/255 split as v*K + v*R/255 with 2^F = 255*K + R
    s1_vk_r  <= (FB+4)'(hue6) * (FB+4)'(K_DIV);
    s1_sk_r  <= (FB+1)'(req.comp_second) * (FB+1)'(K_DIV);
    s1_tk_r  <= (FB+1)'(req.comp_third) * (FB+1)'(K_DIV);
    s1_vr_r  <= 20'(hue6) * 20'(R_DIV);
    s1_sr_r  <= 16'(req.comp_second) * 16'(R_DIV);
    s1_tr_r  <= 16'(req.comp_third) * 16'(R_DIV);
    s1_py_r  <= py;
    s1_prv_r <= prv;
    s1_pgu_r <= pgu;
    s1_pgv_r <= pgv;
    s1_pbu_r <= pbu;
  end

  // ---------------- stage 2: fixed-point hue, sat, third; yuv sums
  logic                   s2_vld_r;
  csrgb_pkg::side_t       s2_side_r;
  logic [FB+2:0]          s2_hp_r;
  logic [FB:0]            s2_sf_r, s2_tf_r;
  logic signed [19:0]     s2_rs_r, s2_gs_r, s2_bs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_side_r <= s1_side_r;
    s2_hp_r   <= (FB+3)'(s1_vk_r + (FB+4)'(csrgb_pkg::div255(s1_vr_r)));
    s2_sf_r   <= s1_sk_r + (FB+1)'(csrgb_pkg::div255({4'b0000, s1_sr_r}));
    s2_tf_r   <= s1_tk_r + (FB+1)'(csrgb_pkg::div255({4'b0000, s1_tr_r}));
    s2_rs_r   <= s1_py_r + s1_prv_r + csrgb_pkg::YUV_RND;
    s2_gs_r   <= s1_py_r - s1_pgu_r - s1_pgv_r + csrgb_pkg::YUV_RND;
    s2_bs_r   <= s1_py_r + s1_pbu_r + csrgb_pkg::YUV_RND;
  end

  // ---------------- stage 3: chroma and triangle weight
  logic [2:0]      sector;
  logic [FB:0]     hp2, hue_dist, hue_wt;
  logic [FB+1:0]   two, a_dist;
  logic [FB:0]     span, c_opa;
  logic [2*FB+1:0] c_prod;

  assign sector   = s2_hp_r[FB+2:FB];
  // odd sectors count from one, so the peak sits at the sector border
  assign hp2      = {sector[0], s2_hp_r[FB-1:0]};
  assign hue_dist = (hp2 >= ONE) ? (hp2 - ONE) : (ONE - hp2);
  assign hue_wt   = (hue_dist >= ONE) ? '0 : (ONE - hue_dist);
  assign two      = {s2_tf_r, 1'b0};
  assign a_dist   = (two >= ONE2) ? (two - ONE2) : (ONE2 - two);
  assign span     = (a_dist >= ONE2) ? '0 : (FB+1)'(ONE2 - a_dist);
  assign c_opa    = (s2_side_r.mode == csrgb_pkg::MODE_HSL) ? span : s2_tf_r;
  assign c_prod   = (2*FB+2)'(c_opa) * (2*FB+2)'(s2_sf_r);

  logic                   s3_vld_r;
  csrgb_pkg::side_t       s3_side_r;
  logic [2:0]             s3_sector_r;
  logic [FB:0]            s3_tri_r, s3_c_r, s3_tf_r;
  logic [7:0]             s3_yr_r, s3_yg_r, s3_yb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_side_r   <= s2_side_r;
    s3_sector_r <= sector;
    s3_tri_r    <= hue_wt;
    s3_c_r      <= c_prod[2*FB:FB];
    s3_tf_r     <= s2_tf_r;
    s3_yr_r     <= csrgb_pkg::clip_yuv(s2_rs_r);
    s3_yg_r     <= csrgb_pkg::clip_yuv(s2_gs_r);
    s3_yb_r     <= csrgb_pkg::clip_yuv(s2_bs_r);
  end

  // ---------------- stage 4: secondary value x and offset m
  logic [2*FB+1:0] x_prod;
  logic [FB:0]     half, m_nxt;

  assign x_prod = (2*FB+2)'(s3_c_r) * (2*FB+2)'(s3_tri_r);
  assign half   = s3_c_r >> 1;

  always_comb begin
    if (s3_side_r.mode == csrgb_pkg::MODE_HSL) begin
      m_nxt = (s3_tf_r >= half) ? (s3_tf_r - half) : '0;
    end else begin
      m_nxt = (s3_tf_r >= s3_c_r) ? (s3_tf_r - s3_c_r) : '0;
    end
  end

  logic                   s4_vld_r;
  csrgb_pkg::side_t       s4_side_r;
  logic [2:0]             s4_sector_r;
  logic [FB:0]            s4_c_r, s4_x_r, s4_m_r;
  logic [7:0]             s4_yr_r, s4_yg_r, s4_yb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    s4_side_r   <= s3_side_r;
    s4_sector_r <= s3_sector_r;
    s4_c_r      <= s3_c_r;
    s4_x_r      <= x_prod[2*FB:FB];
    s4_m_r      <= m_nxt;
    s4_yr_r     <= s3_yr_r;
    s4_yg_r     <= s3_yg_r;
    s4_yb_r     <= s3_yb_r;
  end

  // ---------------- stage 5: sector mapping, scale to bytes, mode select
  logic [2:0][FB:0]    ch_raw;
  logic [2:0][FB+1:0]  ch_sum;
  logic [2:0][FB+9:0]  ch_scl;
  logic [2:0][7:0]     ch_byte;
  csrgb_pkg::rgb_t     rsp_nxt;

  always_comb begin
    // sector 6 (hue 255) falls into the last sector's arm
    case (s4_sector_r)
      3'd0:    ch_raw = {s4_c_r, s4_x_r, (FB+1)'(0)};
      3'd1:    ch_raw = {s4_x_r, s4_c_r, (FB+1)'(0)};
      3'd2:    ch_raw = {(FB+1)'(0), s4_c_r, s4_x_r};
      3'd3:    ch_raw = {(FB+1)'(0), s4_x_r, s4_c_r};
      3'd4:    ch_raw = {s4_x_r, (FB+1)'(0), s4_c_r};
      default: ch_raw = {s4_c_r, (FB+1)'(0), s4_x_r};
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch_sum[i]  = (FB+2)'(ch_raw[i]) + (FB+2)'(s4_m_r);
      ch_scl[i]  = {ch_sum[i], 8'h00} - (FB+10)'(ch_sum[i]);
      ch_byte[i] = (ch_scl[i][FB+9:FB] > 10'd255) ? 8'd255 : ch_scl[i][FB+7:FB];
    end
  end

  always_comb begin
    rsp_nxt.last_pixel = s4_side_r.pix.end_of_image;
    unique case (s4_side_r.mode) inside
      csrgb_pkg::MODE_HSV, csrgb_pkg::MODE_HSL: begin
        rsp_nxt.red   = ch_byte[2];
        rsp_nxt.green = ch_byte[1];
        rsp_nxt.blue  = ch_byte[0];
      end
      csrgb_pkg::MODE_YUV: begin
        rsp_nxt.red   = s4_yr_r;
        rsp_nxt.green = s4_yg_r;
        rsp_nxt.blue  = s4_yb_r;
      end
      default: begin
        rsp_nxt.red   = s4_side_r.pix.comp_first;
        rsp_nxt.green = s4_side_r.pix.comp_second;
        rsp_nxt.blue  = s4_side_r.pix.comp_third;
      end
    endcase
  end

  logic            rsp_vld_r;
  csrgb_pkg::rgb_t rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp_vld_r <= 1'b0;
    end else begin
      rsp_vld_r <= s4_vld_r;
    end
    rsp_r <= rsp_nxt;
  end

  assign rsp_vld = rsp_vld_r;
  assign rsp     = rsp_r;

endmodule

// ----- rtl/core/color_space_to_rgb_pixel.sv -----
// pixel color space converter: one three-byte pixel in, one rgb pixel out.
// request channel: drive in_comp_* and in_end_of_image with start high; the
// request is taken on any clock edge where start is high, busy never rises.
// result channel: out_valid is high for one cycle with out_red_out,
// out_green_out, out_blue_out and out_last_pixel_out; nothing holds it back,
// the receiver must take it in that cycle.
// a pixel passes through the five-stage pipeline (scale products, fixed-point
// operands, chroma multiply, x multiply, byte scaling); throughput is one
// pixel per clock.
// cfg_wr_en/cfg_wr_data write color_mode (0 hsv, 1 hsl, 2 yuv, 3 pass);
// change it only while no pixel is in flight.
// reset (rst_n low, synchronous) drops every pixel in flight and sets the
// mode to hsv.
module color_space_to_rgb_pixel #(
  parameter int FRAC_BITS = csrgb_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_comp_first,
  input  logic [7:0] in_comp_second,
  input  logic [7:0] in_comp_third,
  input  logic       in_end_of_image,
  output logic       out_valid,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic       out_last_pixel_out,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  csrgb_pkg::mode_t mode_r;
  csrgb_pkg::pix_t  req;
  csrgb_pkg::rgb_t  rsp;
  logic             req_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= csrgb_pkg::MODE_HSV;
    end else if (cfg_wr_en) begin
      mode_r <= csrgb_pkg::mode_t'(cfg_wr_data);
    end
  end

  // the pipeline advances every cycle, so a request is never refused
  assign busy    = 1'b0;
  assign req_vld = start && !busy;
  assign req     = '{comp_first:   in_comp_first,
                     comp_second:  in_comp_second,
                     comp_third:   in_comp_third,
                     end_of_image: in_end_of_image};

  csrgb_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .req_vld (req_vld),
    .req     (req),
    .mode    (mode_r),
    .rsp_vld (out_valid),
    .rsp     (rsp)
  );

  assign out_red_out        = rsp.red;
  assign out_green_out      = rsp.green;
  assign out_blue_out       = rsp.blue;
  assign out_last_pixel_out = rsp.last_pixel;

endmodule

// ----- test/color_space_checker.sv -----
`timescale 1ns / 100ps

module color_space_checker #(
  parameter int FRAC_BITS = csrgb_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic [7:0] in_comp_first,
  input  logic [7:0] in_comp_second,
  input  logic [7:0] in_comp_third,
  input  logic       in_end_of_image,
  input  logic       out_valid,
  input  logic [7:0] out_red_out,
  input  logic [7:0] out_green_out,
  input  logic [7:0] out_blue_out,
  input  logic       out_last_pixel_out,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  output int         fail_count,
  output int         pending_pixels
);

  csrgb_pkg::mode_t color_mode;
  csrgb_pkg::rgb_t  expected_rgb[$];

  function automatic logic [7:0] scale_to_byte(input logic [63:0] v);
    logic [63:0] r;
    r = (v * 64'd255) >> FRAC_BITS;
    return (r > 64'd255) ? 8'd255 : r[7:0];
  endfunction

  // hsv and hsl share the sector logic, only chroma and offset differ
  function automatic csrgb_pkg::rgb_t hue_to_rgb(input logic [7:0] hue,
                                                 input logic [7:0] sat,
                                                 input logic [7:0] third,
                                                 input bit is_hsl);
    logic [63:0] one, hp, sector, frac, hp2, hue_dist, hue_wt, sf, tf;
    logic [63:0] two, a, span, half, c, m, x, r, g, b;
    csrgb_pkg::rgb_t res;
    one      = 64'd1 << FRAC_BITS;
    hp       = ((64'(hue) * 64'd6) << FRAC_BITS) / 64'd255;
    sector   = hp >> FRAC_BITS;
    frac     = hp & (one - 64'd1);
    hp2      = frac + (sector[0] ? one : 64'd0);
    hue_dist = (hp2 >= one) ? hp2 - one : one - hp2;
    hue_wt   = (hue_dist >= one) ? 64'd0 : one - hue_dist;
    sf       = (64'(sat) << FRAC_BITS) / 64'd255;
    tf       = (64'(third) << FRAC_BITS) / 64'd255;
    if (is_hsl) begin
      two  = tf * 64'd2;
      a    = (two >= one) ? two - one : one - two;
      span = (a >= one) ? 64'd0 : one - a;
      c    = (span * sf) >> FRAC_BITS;
      half = c >> 1;
      m    = (tf >= half) ? tf - half : 64'd0;
    end else begin
      c = (tf * sf) >> FRAC_BITS;
      m = (tf >= c) ? tf - c : 64'd0;
    end
    // x keeps the parity of the unclamped sector, so hue 255 wraps to red
    x = (c * hue_wt) >> FRAC_BITS;
    if (sector > 64'd5) begin
      sector = 64'd5;
    end
    case (sector)
      64'd0: begin r = c; g = x; b = 0; end
      64'd1: begin r = x; g = c; b = 0; end
      64'd2: begin r = 0; g = c; b = x; end
      64'd3: begin r = 0; g = x; b = c; end
      64'd4: begin r = x; g = 0; b = c; end
      default: begin r = c; g = 0; b = x; end
    endcase
    res.red        = scale_to_byte(r + m);
    res.green      = scale_to_byte(g + m);
    res.blue       = scale_to_byte(b + m);
    res.last_pixel = 1'b0;
    return res;
  endfunction

  function automatic logic [7:0] yuv_clip(input int sum);
    int q;
    if (sum < 0) begin
      return 8'd0;
    end
    q = sum >>> 8;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic csrgb_pkg::rgb_t convert_pixel(input csrgb_pkg::mode_t mode,
                                                    input csrgb_pkg::pix_t p);
    int   y, u, v;
    csrgb_pkg::rgb_t res;
    case (mode)
      csrgb_pkg::MODE_HSV:
        res = hue_to_rgb(p.comp_first, p.comp_second, p.comp_third, 1'b0);
      csrgb_pkg::MODE_HSL:
        res = hue_to_rgb(p.comp_first, p.comp_second, p.comp_third, 1'b1);
      csrgb_pkg::MODE_YUV: begin
        y = int'(p.comp_first) - 16;
        u = int'(p.comp_second) - 128;
        v = int'(p.comp_third) - 128;
        res.red   = yuv_clip(298 * y + 409 * v + 128);
        res.green = yuv_clip(298 * y - 100 * u - 208 * v + 128);
        res.blue  = yuv_clip(298 * y + 516 * u + 128);
      end
      default: begin
        res.red   = p.comp_first;
        res.green = p.comp_second;
        res.blue  = p.comp_third;
      end
    endcase
    res.last_pixel = p.end_of_image;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t checker: %s", $time, what);
    fail_count++;
  endtask

  initial begin
    fail_count     = 0;
    pending_pixels = 0;
    color_mode     = csrgb_pkg::MODE_HSV;
  end

  always @(posedge clk) begin
    csrgb_pkg::rgb_t want;
    csrgb_pkg::pix_t req;
    if (!rst_n) begin
      color_mode = csrgb_pkg::MODE_HSV;
      expected_rgb.delete();
    end else begin
      if (out_valid) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = expected_rgb.pop_front();
          if (out_red_out !== want.red)
            report_mismatch($sformatf("red %0d, expected %0d", out_red_out, want.red));
          if (out_green_out !== want.green)
            report_mismatch($sformatf("green %0d, expected %0d", out_green_out,
                                      want.green));
          if (out_blue_out !== want.blue)
            report_mismatch($sformatf("blue %0d, expected %0d", out_blue_out, want.blue));
          if (out_last_pixel_out !== want.last_pixel)
            report_mismatch($sformatf("last pixel %0b, expected %0b", out_last_pixel_out,
                                      want.last_pixel));
        end
      end
      if (start && !busy) begin
        req  = '{in_comp_first, in_comp_second, in_comp_third, in_end_of_image};
        want = convert_pixel(color_mode, req);
        expected_rgb.insert(expected_rgb.size(), want);
      end
      // mode taken after the request of the same edge, as the register does
      if (cfg_wr_en) begin
        color_mode = csrgb_pkg::mode_t'(cfg_wr_data);
      end
    end
    pending_pixels <= expected_rgb.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [7:0] in_comp_first;
  logic [7:0] in_comp_second;
  logic [7:0] in_comp_third;
  logic       in_end_of_image;
  logic       out_valid;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic       out_last_pixel_out;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;
  int         fail_count;
  int         pending_pixels;
  int         idle_pct;

  color_space_to_rgb_pixel i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_comp_first      (in_comp_first),
    .in_comp_second     (in_comp_second),
    .in_comp_third      (in_comp_third),
    .in_end_of_image    (in_end_of_image),
    .out_valid          (out_valid),
    .out_red_out        (out_red_out),
    .out_green_out      (out_green_out),
    .out_blue_out       (out_blue_out),
    .out_last_pixel_out (out_last_pixel_out),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  color_space_checker i_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_comp_first      (in_comp_first),
    .in_comp_second     (in_comp_second),
    .in_comp_third      (in_comp_third),
    .in_end_of_image    (in_end_of_image),
    .out_valid          (out_valid),
    .out_red_out        (out_red_out),
    .out_green_out      (out_green_out),
    .out_blue_out       (out_blue_out),
    .out_last_pixel_out (out_last_pixel_out),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .pending_pixels     (pending_pixels)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // entered and left at a falling edge; start stays high between back-to-back requests
  task automatic send_pixel(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start           <= 1'b1;
    in_comp_first   <= a;
    in_comp_second  <= b;
    in_comp_third   <= c;
    in_end_of_image <= eoi;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_pixels;
    start <= 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_mode(input csrgb_pkg::mode_t mode);
    drain_pixels();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte;
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(250, 255));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int idle_tbl[4];
    rst_n           = 1'b0;
    start           = 1'b0;
    in_comp_first   = 8'd0;
    in_comp_second  = 8'd0;
    in_comp_third   = 8'd0;
    in_end_of_image = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = csrgb_pkg::MODE_HSV;
    idle_pct        = 0;
    idle_tbl        = '{0, 47, 0, 13};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_mode(csrgb_pkg::MODE_HSV);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);  // hue wraps back to red
    send_pixel(8'd43, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd200, 1'b0);
    send_pixel(8'd200, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd85, 8'd255, 8'd0, 1'b1);

    write_mode(csrgb_pkg::MODE_HSL);
    send_pixel(8'd0, 8'd255, 8'd128, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd128, 1'b1);
    send_pixel(8'd170, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd21, 8'd200, 8'd0, 1'b0);
    send_pixel(8'd128, 8'd77, 8'd64, 1'b0);

    write_mode(csrgb_pkg::MODE_YUV);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);        // negative sums clip low
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);  // large sums clip high
    send_pixel(8'd16, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd235, 8'd128, 8'd128, 1'b0);
    send_pixel(8'd128, 8'd0, 8'd255, 1'b0);

    write_mode(csrgb_pkg::MODE_PASS);
    send_pixel(8'd0, 8'd255, 8'd170, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd85, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      write_mode(csrgb_pkg::mode_t'(phase % 4));
      idle_pct = idle_tbl[(phase + phase / 4) % 4];
      for (int n = 0; n < 80; n++) begin
        send_pixel(pick_byte(), pick_byte(), pick_byte(), $urandom_range(15) == 0);
      end
    end

    drain_pixels();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

endmodule
